// ----- rtl/fpa_pkg.sv -----
// ----------------------------------------------------------------------------
// fpa_pkg
// Shared codes, sideband record and saturation helpers of the fixed-point ALU.
// ----------------------------------------------------------------------------
package fpa_pkg;

    localparam int FRAC_BITS_DEF = 8;

    localparam logic [3:0] ACT_ADD = 4'd0;
    localparam logic [3:0] ACT_SUB = 4'd1;
    localparam logic [3:0] ACT_MUL = 4'd2;
    localparam logic [3:0] ACT_DIV = 4'd3;
    localparam logic [3:0] ACT_MIN = 4'd4;
    localparam logic [3:0] ACT_MAX = 4'd5;
    localparam logic [3:0] ACT_INC = 4'd6;
    localparam logic [3:0] ACT_DEC = 4'd7;
    localparam logic [3:0] ACT_I2F = 4'd8;
    localparam logic [3:0] ACT_F2I = 4'd9;

    // per-item data that rides along the divider pipeline
    typedef struct packed {
        logic [3:0]  act;
        logic        gt;
        logic        lt;
        logic        eq;
        logic        neg;
        logic        dz;
        logic [31:0] res;
        logic        ovf;
        logic [31:0] mag_a;
        logic [31:0] mag_b;
        logic [63:0] prod;
    } t_side;

    // returns {overflow, result}
    function automatic logic [32:0] sat_val(input logic signed [63:0] v);
        logic [32:0] o;
        if (v > $signed(64'h0000_0000_7FFF_FFFF)) begin
            o = {1'b1, 32'h7FFF_FFFF};
        end else if (v < $signed(64'hFFFF_FFFF_8000_0000)) begin
            o = {1'b1, 32'h8000_0000};
        end else begin
            o = {1'b0, v[31:0]};
        end
        return o;
    endfunction

    // signed magnitude to saturated two's complement, returns {overflow, result}
    function automatic logic [32:0] sat_mag(input logic neg, input logic [64:0] mag);
        logic [32:0] o;
        logic [64:0] m;
        m = 65'd0 - mag;
        if (neg) begin
            if (mag > 65'h0_8000_0000) begin
                o = {1'b1, 32'h8000_0000};
            end else begin
                o = {1'b0, m[31:0]};
            end
        end else begin
            if (mag > 65'h0_7FFF_FFFF) begin
                o = {1'b1, 32'h7FFF_FFFF};
            end else begin
                o = {1'b0, mag[31:0]};
            end
        end
        return o;
    endfunction

endpackage

// ----- rtl/fpa_div.sv -----
// ----------------------------------------------------------------------------
// fpa_div
// Pipelined restoring divider, one quotient bit per stage, NW stages.
// ----------------------------------------------------------------------------
module fpa_div #(
    parameter int NW = 32 + fpa_pkg::FRAC_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [NW-1:0] i_num,
    input  logic [31:0]   i_den,
    output logic [NW-1:0] o_quo,
    output logic [32:0]   o_rem
);

    logic [32:0]   r_rem [NW];
    logic [NW-1:0] r_num [NW];
    logic [NW-1:0] r_quo [NW];
    logic [31:0]   r_den [NW];

    for (genvar g = 0; g < NW; g++) begin : g_stage
        logic [32:0]   p_rem;
        logic [NW-1:0] p_num;
        logic [NW-1:0] p_quo;
        logic [31:0]   p_den;
        logic [32:0]   trial;
        logic          ge;

        if (g == 0) begin : g_first
            assign p_rem = 33'd0;
            assign p_num = i_num;
            assign p_quo = '0;
            assign p_den = i_den;
        end else begin : g_next
            assign p_rem = r_rem[g-1];
            assign p_num = r_num[g-1];
            assign p_quo = r_quo[g-1];
            assign p_den = r_den[g-1];
        end

        assign trial = {p_rem[31:0], p_num[NW-1]};
        assign ge    = trial >= {1'b0, p_den};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[g] <= ge ? trial - {1'b0, p_den} : trial;
                r_num[g] <= {p_num[NW-2:0], 1'b0};
                r_quo[g] <= {p_quo[NW-2:0], ge};
                r_den[g] <= p_den;
            end
        end
    end

    assign o_quo = r_quo[NW-1];
    assign o_rem = r_rem[NW-1];

endmodule

// ----- rtl/fpa_out.sv -----
// ----------------------------------------------------------------------------
// fpa_out
// Final stage: rounds product and quotient, saturates, selects the result.
// ----------------------------------------------------------------------------
module fpa_out #(
    parameter int FRAC_BITS = fpa_pkg::FRAC_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_en,
    input  fpa_pkg::t_side         i_side,
    input  logic [32+FRAC_BITS-1:0] i_quo,
    input  logic [32:0]            i_rem,
    output logic [31:0]            o_result,
    output logic                   o_a_greater,
    output logic                   o_a_less,
    output logic                   o_a_equal,
    output logic                   o_overflow,
    output logic                   o_divide_by_zero
);
    import fpa_pkg::*;

    localparam int NW = 32 + FRAC_BITS;

    logic [63:0] mul_q;
    logic [NW:0] div_q;
    logic        up;
    logic [32:0] mul_s;
    logic [32:0] div_s;
    logic [32:0] n_sel;

    always_comb begin
        mul_q = (i_side.prod + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        // round half away: bump when twice the remainder reaches the divisor
        up    = {i_rem, 1'b0} >= {2'b00, i_side.mag_b};
        div_q = {1'b0, i_quo} + {{NW{1'b0}}, up};
        mul_s = sat_mag(i_side.neg, {1'b0, mul_q});
        div_s = sat_mag(i_side.neg, {{(64-NW){1'b0}}, div_q});
        case (i_side.act)
            ACT_MUL: n_sel = mul_s;
            ACT_DIV: n_sel = i_side.dz ? 33'd0 : div_s;
            default: n_sel = {i_side.ovf, i_side.res};
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_result         <= n_sel[31:0];
            o_overflow       <= n_sel[32];
            o_a_greater      <= i_side.gt;
            o_a_less         <= i_side.lt;
            o_a_equal        <= i_side.eq;
            o_divide_by_zero <= i_side.dz;
        end
    end

endmodule

// ----- rtl/fixed_point_alu.sv -----
// ----------------------------------------------------------------------------
// fixed_point_alu
// Signed fixed-point ALU: add, sub, mul, div, min, max, inc, dec, conversions.
// ----------------------------------------------------------------------------
// channel  direction  handshake           payload
// request  in         i_valid / o_ready   i_action, i_operand_a, i_operand_b
// result   out        o_valid / i_ready   o_result, compare flags, overflow,
//                                         o_divide_by_zero
//
// One request enters per cycle while the output is not stalled; each result passes
// the input stage, the divider, which retires one quotient bit per stage, and fpa_out.
// All stages advance together; a stalled output holds the whole pipe in place.
// Reset clears only the valid bits.
// ----------------------------------------------------------------------------
module fixed_point_alu #(
    parameter int FRAC_BITS = fpa_pkg::FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [3:0]         i_action,
    input  logic signed [31:0] i_operand_a,
    input  logic signed [31:0] i_operand_b,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [31:0] o_result,
    output logic               o_a_greater,
    output logic               o_a_less,
    output logic               o_a_equal,
    output logic               o_overflow,
    output logic               o_divide_by_zero
);
    import fpa_pkg::*;

    localparam int NW = 32 + FRAC_BITS;

    logic               en;
    logic [NW+1:0]      r_vld;
    t_side              r_side [NW+1];
    t_side              n_side;
    t_side              n_side1;
    logic signed [32:0] sum;
    logic signed [32:0] dif;
    logic signed [32:0] inc;
    logic signed [32:0] dec;
    logic signed [63:0] a64;
    logic [NW-1:0]      quo;
    logic [32:0]        rem;
    logic [31:0]        res_out;

    assign en      = ~r_vld[NW+1] | i_ready;
    assign o_ready = en;
    assign o_valid = r_vld[NW+1];

    always_comb begin
        sum = {i_operand_a[31], i_operand_a} + {i_operand_b[31], i_operand_b};
        dif = {i_operand_a[31], i_operand_a} - {i_operand_b[31], i_operand_b};
        inc = {i_operand_a[31], i_operand_a} + 33'sd1;
        dec = {i_operand_a[31], i_operand_a} - 33'sd1;
        a64 = {{32{i_operand_a[31]}}, i_operand_a};
        n_side       = '0;
        n_side.act   = i_action;
        n_side.gt    = i_operand_a > i_operand_b;
        n_side.lt    = i_operand_a < i_operand_b;
        n_side.eq    = i_operand_a == i_operand_b;
        n_side.neg   = i_operand_a[31] ^ i_operand_b[31];
        n_side.dz    = (i_action == ACT_DIV) && (i_operand_b == 32'sd0);
        n_side.mag_a = i_operand_a[31] ? 32'd0 - i_operand_a : i_operand_a;
        n_side.mag_b = i_operand_b[31] ? 32'd0 - i_operand_b : i_operand_b;
        case (i_action)
            ACT_ADD: {n_side.ovf, n_side.res} = sat_val({{31{sum[32]}}, sum});
            ACT_SUB: {n_side.ovf, n_side.res} = sat_val({{31{dif[32]}}, dif});
            ACT_INC: {n_side.ovf, n_side.res} = sat_val({{31{inc[32]}}, inc});
            ACT_DEC: {n_side.ovf, n_side.res} = sat_val({{31{dec[32]}}, dec});
            ACT_I2F: {n_side.ovf, n_side.res} = sat_val(a64 <<< FRAC_BITS);
            ACT_MIN: n_side.res = n_side.lt ? i_operand_a : i_operand_b;
            ACT_MAX: n_side.res = n_side.gt ? i_operand_a : i_operand_b;
            ACT_F2I: n_side.res = i_operand_a >>> FRAC_BITS;
            default: n_side.res = 32'd0;
        endcase
    end

    // multiply in the second stage, alongside the divider
    always_comb begin
        n_side1      = r_side[0];
        n_side1.prod = {32'd0, r_side[0].mag_a} * {32'd0, r_side[0].mag_b};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NW:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_side[0] <= n_side;
            r_side[1] <= n_side1;
            for (int k = 2; k <= NW; k++) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    fpa_div #(
        .NW(NW)
    ) u_div (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num ({r_side[0].mag_a, {FRAC_BITS{1'b0}}}),
        .i_den (r_side[0].mag_b),
        .o_quo (quo),
        .o_rem (rem)
    );

    fpa_out #(
        .FRAC_BITS(FRAC_BITS)
    ) u_out (
        .i_clk            (i_clk),
        .i_en             (en),
        .i_side           (r_side[NW]),
        .i_quo            (quo),
        .i_rem            (rem),
        .o_result         (res_out),
        .o_a_greater      (o_a_greater),
        .o_a_less         (o_a_less),
        .o_a_equal        (o_a_equal),
        .o_overflow       (o_overflow),
        .o_divide_by_zero (o_divide_by_zero)
    );

    assign o_result = res_out;

    a_flags_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $onehot({o_a_greater, o_a_less, o_a_equal}))
        else $error("compare flags not one-hot");

    a_dz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_divide_by_zero) |-> (o_result == 32'sd0 && !o_overflow))
        else $error("divide by zero result not clean");

    a_ovf_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_overflow) |->
            (o_result == 32'sh7FFF_FFFF || o_result == 32'sh8000_0000))
        else $error("overflow without saturated result");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_result)))
        else $error("stalled result changed");

endmodule
